### design/fplpq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fplpq_pkg
// Shared constants and types for the priority queue with fifo order per level.
// ----------------------------------------------------------------------------
package fplpq_pkg;

  localparam int unsigned CAPACITY_DEFAULT = 64;
  localparam int unsigned LEVELS_DEFAULT   = 16;

  localparam int unsigned LEVEL_W  = 4;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned REQ_W    = 2;
  localparam int unsigned STATUS_W = 2;

  localparam logic [REQ_W-1:0] REQ_ENQUEUE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DEQUEUE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_PEEK    = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_READ  = 3'b010,
    ST_WRITE = 3'b100
  } state_e;

endpackage : fplpq_pkg
`default_nettype wire

### design/fplpq_first_busy.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fplpq_first_busy
// Priority encoder: lowest level whose busy flag is set, plus an empty flag.
// ----------------------------------------------------------------------------
module fplpq_first_busy #(
  parameter int unsigned LEVELS = fplpq_pkg::LEVELS_DEFAULT,
  localparam int unsigned LW    = $clog2(LEVELS)
) (
  input  wire logic [LEVELS-1:0] busy_i,
  output      logic [LW-1:0]     front_o,
  output      logic              empty_o
);

  always_comb begin
    front_o = '0;
    for (int k = LEVELS - 1; k >= 0; k--) begin
      if (busy_i[k]) begin
        front_o = LW'(k);
      end
    end
  end

  assign empty_o = ~|busy_i;

endmodule : fplpq_first_busy
`default_nettype wire

### design/fifo_per_level_priority_queue_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fifo_per_level_priority_queue_unit
// Priority queue, smaller level served first, arrival order within a level.
// Flow: level head/tail are read as the request word is taken, then entry
// value/link at that head in the read state; the result word is registered in
// write-back when the output is not stalled. New requests stall until then.
// Reset: busy flags and free-slot counters clear at once; the memories are
// not cleared and no clearing pass runs, so requests are taken right away.
// ----------------------------------------------------------------------------
module fifo_per_level_priority_queue_unit #(
  parameter int unsigned CAPACITY = fplpq_pkg::CAPACITY_DEFAULT,
  parameter int unsigned LEVELS   = fplpq_pkg::LEVELS_DEFAULT
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   in_valid_i,
  output      logic                                   in_stall_o,
  input  wire logic [fplpq_pkg::REQ_W-1:0]            req_type_i,
  input  wire logic signed [fplpq_pkg::VALUE_W-1:0]   value_i,
  input  wire logic [fplpq_pkg::LEVEL_W-1:0]          level_i,
  output      logic                                   out_valid_o,
  input  wire logic                                   out_stall_i,
  output      logic [fplpq_pkg::STATUS_W-1:0]         status_o,
  output      logic signed [fplpq_pkg::VALUE_W-1:0]   out_value_o,
  output      logic [fplpq_pkg::LEVEL_W-1:0]          out_level_o
);

  localparam int unsigned LW = $clog2(LEVELS);
  localparam int unsigned SW = $clog2(CAPACITY);
  localparam int unsigned TW = $clog2(CAPACITY + 1);
  localparam int unsigned EW = (LW > fplpq_pkg::LEVEL_W) ? LW : fplpq_pkg::LEVEL_W;

  // memories
  logic signed [fplpq_pkg::VALUE_W-1:0] value_mem [CAPACITY];
  logic [SW-1:0]                        link_mem  [CAPACITY];
  logic [SW-1:0]                        free_mem  [CAPACITY];
  logic [SW-1:0]                        head_mem  [LEVELS];
  logic [SW-1:0]                        tail_mem  [LEVELS];

  fplpq_pkg::state_e state_q, state_d;

  logic [LEVELS-1:0]               busy_q, busy_d;
  logic [TW-1:0]                   free_top_q, free_top_d;
  logic [TW-1:0]                   fresh_q, fresh_d;
  logic                            out_valid_q;

  logic [fplpq_pkg::REQ_W-1:0]          req_q;
  logic signed [fplpq_pkg::VALUE_W-1:0] val_q;
  logic [LW-1:0]                        lvl_q;
  logic                                 empty_q;
  logic                                 full_q;
  logic                                 busy_hit_q;
  logic [SW-1:0]                        head_rd_q;
  logic [SW-1:0]                        tail_rd_q;
  logic [SW-1:0]                        free_rd_q;
  logic signed [fplpq_pkg::VALUE_W-1:0] value_rd_q;
  logic [SW-1:0]                        link_rd_q;

  logic [fplpq_pkg::STATUS_W-1:0]       status_q, status_d;
  logic signed [fplpq_pkg::VALUE_W-1:0] out_value_q, out_value_d;
  logic [fplpq_pkg::LEVEL_W-1:0]        out_level_q, out_level_d;

  logic [LW-1:0] front;
  logic          all_empty;
  logic [LW-1:0] lvl_sat;
  logic [LW-1:0] lvl_sel;
  logic          is_enq;
  logic          in_accept;
  logic          wr_fire;
  logic          enq_ok;
  logic          deq_ok;
  logic [SW-1:0] alloc_slot;
  logic [TW-1:0] top_m1;
  logic [EW-1:0] lvl_ext;

  logic          value_we;
  logic          link_we;
  logic          head_we;
  logic [SW-1:0] head_wdata;
  logic          tail_we;
  logic          free_we;

  fplpq_first_busy #(
    .LEVELS (LEVELS)
  ) u_first_busy (
    .busy_i  (busy_q),
    .front_o (front),
    .empty_o (all_empty)
  );

  assign in_stall_o = (state_q != fplpq_pkg::ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  assign lvl_sat = (32'(level_i) < LEVELS) ? LW'(level_i) : LW'(LEVELS - 1);
  assign lvl_sel = (req_type_i == fplpq_pkg::REQ_ENQUEUE) ? lvl_sat : front;
  assign top_m1  = free_top_q - 1'b1;

  assign is_enq     = (req_q == fplpq_pkg::REQ_ENQUEUE);
  assign wr_fire    = (state_q == fplpq_pkg::ST_WRITE) && (!out_valid_q || !out_stall_i);
  assign enq_ok     = is_enq && !full_q;
  assign deq_ok     = (req_q == fplpq_pkg::REQ_DEQUEUE) && !empty_q;
  assign alloc_slot = (free_top_q != '0) ? free_rd_q : fresh_q[SW-1:0];
  assign lvl_ext    = EW'(lvl_q);

  // write enables of the write-back cycle
  always_comb begin
    value_we   = wr_fire && enq_ok;
    link_we    = wr_fire && enq_ok && busy_hit_q;
    tail_we    = wr_fire && enq_ok;
    free_we    = wr_fire && deq_ok;
    head_we    = 1'b0;
    head_wdata = alloc_slot;
    if (wr_fire && enq_ok && !busy_hit_q) begin
      head_we = 1'b1;
    end else if (wr_fire && deq_ok && (head_rd_q != tail_rd_q)) begin
      head_we    = 1'b1;
      head_wdata = link_rd_q;
    end
  end

  always_comb begin
    state_d     = state_q;
    busy_d      = busy_q;
    free_top_d  = free_top_q;
    fresh_d     = fresh_q;
    status_d    = status_q;
    out_value_d = out_value_q;
    out_level_d = out_level_q;
    case (state_q)
      fplpq_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_d = fplpq_pkg::ST_READ;
        end
      end
      fplpq_pkg::ST_READ: begin
        state_d = fplpq_pkg::ST_WRITE;
      end
      fplpq_pkg::ST_WRITE: begin
        if (wr_fire) begin
          state_d     = fplpq_pkg::ST_IDLE;
          status_d    = fplpq_pkg::STATUS_OK;
          out_value_d = '0;
          out_level_d = '0;
          if (is_enq) begin
            if (full_q) begin
              status_d = fplpq_pkg::STATUS_FULL;
            end else begin
              busy_d[lvl_q] = 1'b1;
              if (free_top_q != '0) begin
                free_top_d = top_m1;
              end else begin
                fresh_d = fresh_q + 1'b1;
              end
            end
          end else if (empty_q) begin
            status_d = fplpq_pkg::STATUS_EMPTY;
          end else begin
            out_value_d = value_rd_q;
            out_level_d = lvl_ext[fplpq_pkg::LEVEL_W-1:0];
            if (deq_ok) begin
              free_top_d = free_top_q + 1'b1;
              if (head_rd_q == tail_rd_q) begin
                busy_d[lvl_q] = 1'b0;
              end
            end
          end
        end
      end
      default: begin
        state_d = fplpq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fplpq_pkg::ST_IDLE;
      busy_q      <= '0;
      free_top_q  <= '0;
      fresh_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      busy_q     <= busy_d;
      free_top_q <= free_top_d;
      fresh_q    <= fresh_d;
      if (wr_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // request capture and result registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q      <= req_type_i;
      val_q      <= value_i;
      lvl_q      <= lvl_sel;
      empty_q    <= all_empty;
      full_q     <= (free_top_q == '0) && (fresh_q == TW'(CAPACITY));
      busy_hit_q <= busy_q[lvl_sel];
    end
    status_q    <= status_d;
    out_value_q <= out_value_d;
    out_level_q <= out_level_d;
  end

  // level head and tail memories
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      head_rd_q <= head_mem[lvl_sel];
    end
    if (head_we) begin
      head_mem[lvl_q] <= head_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      tail_rd_q <= tail_mem[lvl_sel];
    end
    if (tail_we) begin
      tail_mem[lvl_q] <= alloc_slot;
    end
  end

  // free slot stack
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      free_rd_q <= free_mem[top_m1[SW-1:0]];
    end
    if (free_we) begin
      free_mem[free_top_q[SW-1:0]] <= head_rd_q;
    end
  end

  // entry value and link memories
  always_ff @(posedge clk_i) begin
    if (state_q == fplpq_pkg::ST_READ) begin
      value_rd_q <= value_mem[head_rd_q];
    end
    if (value_we) begin
      value_mem[alloc_slot] <= val_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == fplpq_pkg::ST_READ) begin
      link_rd_q <= link_mem[head_rd_q];
    end
    if (link_we) begin
      link_mem[tail_rd_q] <= alloc_slot;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign out_value_o = out_value_q;
  assign out_level_o = out_level_q;

  // assertions
  a_sequence : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == fplpq_pkg::ST_READ) ##1 (state_q == fplpq_pkg::ST_WRITE))
    else $error("request did not walk read then write-back");

  a_result_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == fplpq_pkg::ST_WRITE))
    else $error("result word appeared outside write-back");

  a_free_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fresh_q <= TW'(CAPACITY)) && (free_top_q <= fresh_q))
    else $error("free slot accounting out of range");

  a_full_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q == '0) |-> (free_top_q == fresh_q))
    else $error("slots in use while every level is empty");

endmodule : fifo_per_level_priority_queue_unit
`default_nettype wire

### sim/fplpq_order_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fplpq_order_checker
// Watches both channels of the priority queue unit. Each request word taken
// is run through a behavioral copy of the queue: one fifo per level, lowest
// busy level served first. The response it should give is queued, and each
// response word taken is compared field by field with the oldest one queued.
// ----------------------------------------------------------------------------
module fplpq_order_checker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  input  logic                                 in_stall_i,
  input  logic [fplpq_pkg::REQ_W-1:0]          req_type_i,
  input  logic signed [fplpq_pkg::VALUE_W-1:0] value_i,
  input  logic [fplpq_pkg::LEVEL_W-1:0]        level_i,
  input  logic                                 out_valid_i,
  input  logic                                 out_stall_i,
  input  logic [fplpq_pkg::STATUS_W-1:0]       status_i,
  input  logic signed [fplpq_pkg::VALUE_W-1:0] out_value_i,
  input  logic [fplpq_pkg::LEVEL_W-1:0]        out_level_i,
  output int                                   fail_count_o,
  output int                                   due_count_o
);
  import fplpq_pkg::*;

  localparam int unsigned SLOT_COUNT  = CAPACITY_DEFAULT;
  localparam int unsigned LEVEL_COUNT = LEVELS_DEFAULT;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] value;
    logic [LEVEL_W-1:0]        level;
  } response_t;

  response_t                 due_responses[$];
  logic signed [VALUE_W-1:0] level_fifo[LEVEL_COUNT][$];
  int unsigned               slots_used = 0;
  response_t                 oldest;

  function automatic response_t serve_request(input logic [REQ_W-1:0] req,
                                              input logic signed [VALUE_W-1:0] val,
                                              input logic [LEVEL_W-1:0] lvl);
    response_t   resp;
    int unsigned lv;
    int unsigned k;
    bit          found;
    resp.status = STATUS_OK;
    resp.value  = '0;
    resp.level  = '0;
    lv = (lvl >= LEVEL_COUNT) ? LEVEL_COUNT - 1 : lvl;
    if (req == REQ_ENQUEUE) begin
      if (slots_used >= SLOT_COUNT) begin
        resp.status = STATUS_FULL;
      end else begin
        level_fifo[lv].push_back(val);
        slots_used++;
      end
    end else begin
      // dequeue, peek and the spare code all look at the front entry
      resp.status = STATUS_EMPTY;
      found = 1'b0;
      for (k = 0; k < LEVEL_COUNT; k++) begin
        if (!found && level_fifo[k].size() != 0) begin
          found       = 1'b1;
          resp.status = STATUS_OK;
          resp.value  = level_fifo[k][0];
          resp.level  = k[LEVEL_W-1:0];
          if (req == REQ_DEQUEUE) begin
            void'(level_fifo[k].pop_front());
            slots_used--;
          end
        end
      end
    end
    return resp;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $realtime, what);
    fail_count_o++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (due_responses.size() == 0) begin
          report_mismatch("response word with none due");
        end else begin
          oldest = due_responses.pop_front();
          if (status_i !== oldest.status)
            report_mismatch($sformatf("status got %0d want %0d", status_i, oldest.status));
          if (out_value_i !== oldest.value)
            report_mismatch($sformatf("value got %0d want %0d", out_value_i, oldest.value));
          if (out_level_i !== oldest.level)
            report_mismatch($sformatf("level got %0d want %0d", out_level_i, oldest.level));
        end
      end
      if (in_valid_i && !in_stall_i)
        due_responses.push_back(serve_request(req_type_i, value_i, level_i));
    end
    due_count_o = due_responses.size();
  end

endmodule : fplpq_order_checker

### sim/fifo_per_level_priority_queue_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_per_level_priority_queue_unit_tb
// Drives request words into the priority queue unit: a directed opening on
// the empty queue, extreme values and all request codes, then random fill,
// drain and mixed bursts under several idle and stall patterns, with one long
// receiver hold-off and a full drain between patterns. The order checker
// beside the block predicts and compares every response word.
// ----------------------------------------------------------------------------
module fifo_per_level_priority_queue_unit_tb;
  import fplpq_pkg::*;

  localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_WORDS   = 375;

  typedef enum int {BURST_FILL, BURST_DRAIN, BURST_MIXED} burst_e;

  logic                      clk_i     = 1'b0;
  logic                      rst_ni    = 1'b0;
  logic                      in_valid  = 1'b0;
  logic                      in_stall;
  logic [REQ_W-1:0]          req_type  = REQ_ENQUEUE;
  logic signed [VALUE_W-1:0] req_value = '0;
  logic [LEVEL_W-1:0]        req_level = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [STATUS_W-1:0]       status;
  logic signed [VALUE_W-1:0] out_value;
  logic [LEVEL_W-1:0]        out_level;

  int fail_total;
  int due_count;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_seq      = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int words_sent    = 0;

  always #10 clk_i = ~clk_i;

  fifo_per_level_priority_queue_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .req_type_i  (req_type),
    .value_i     (req_value),
    .level_i     (req_level),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .status_o    (status),
    .out_value_o (out_value),
    .out_level_o (out_level)
  );

  fplpq_order_checker checker_u (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .req_type_i   (req_type),
    .value_i      (req_value),
    .level_i      (req_level),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .status_i     (status),
    .out_value_i  (out_value),
    .out_level_i  (out_level),
    .fail_count_o (fail_total),
    .due_count_o  (due_count)
  );

  // receiver side, with an occasional long hold-off
  always @(negedge clk_i) begin
    if (hold_seen != hold_seq) begin
      hold_seen = hold_seq;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall = 1'b1;
    end else begin
      out_stall = ($urandom_range(99) < stall_pct);
    end
  end

  // called at a falling edge; returns at the falling edge after the word is taken
  task automatic offer(input logic [REQ_W-1:0] req, input logic signed [VALUE_W-1:0] val,
                       input logic [LEVEL_W-1:0] lvl);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk_i);
    end
    in_valid  = 1'b1;
    req_type  = req;
    req_value = val;
    req_level = lvl;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    @(negedge clk_i);
    words_sent++;
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    @(negedge clk_i);
    while (due_count != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  task automatic run_burst(input burst_e kind, input int len);
    int                        n;
    int                        pick;
    bit                        narrow;
    logic [REQ_W-1:0]          req;
    logic signed [VALUE_W-1:0] val;
    logic [LEVEL_W-1:0]        lvl;
    narrow = 1'($urandom_range(1));
    for (n = 0; n < len; n++) begin
      pick = $urandom_range(99);
      case (kind)
        BURST_FILL: begin
          req = (pick < 90) ? REQ_ENQUEUE : (pick < 95) ? REQ_DEQUEUE : REQ_PEEK;
        end
        BURST_DRAIN: begin
          req = (pick < 80) ? REQ_DEQUEUE : (pick < 92) ? REQ_PEEK :
                (pick < 97) ? REQ_ENQUEUE : REQ_SPARE;
        end
        default: begin
          req = (pick < 45) ? REQ_ENQUEUE : (pick < 80) ? REQ_DEQUEUE :
                (pick < 93) ? REQ_PEEK : REQ_SPARE;
        end
      endcase
      case ($urandom_range(11))
        0:       val = 32'sh7fff_ffff;
        1:       val = 32'sh8000_0000;
        2:       val = -32'sd1;
        default: val = $urandom;
      endcase
      // in narrow bursts four levels only (0, 5, 10, 15), so that each level list grows deep
      lvl = narrow ? LEVEL_W'($urandom_range(3) * 5) : LEVEL_W'($urandom_range(15));
      offer(req, val, lvl);
    end
  endtask

  task automatic run_phase(input int idle_pct, input int stalls_pct);
    int target;
    send_idle_pct = idle_pct;
    stall_pct     = stalls_pct;
    target        = words_sent + PHASE_WORDS;
    run_burst(BURST_FILL, 70);
    run_burst(BURST_DRAIN, 72);
    while (words_sent < target)
      run_burst(burst_e'($urandom_range(2)), $urandom_range(30, 60));
    wait_drained();
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // empty queue, then extremes, then every request code
    offer(REQ_DEQUEUE, 32'sd5, 4'd3);
    offer(REQ_PEEK, 32'sd6, 4'd0);
    offer(REQ_SPARE, 32'sd7, 4'd15);
    offer(REQ_ENQUEUE, 32'sh7fff_ffff, 4'd15);
    offer(REQ_ENQUEUE, 32'sh8000_0000, 4'd0);
    offer(REQ_ENQUEUE, 32'sd0, 4'd7);
    offer(REQ_ENQUEUE, -32'sd1, 4'd0);
    offer(REQ_ENQUEUE, 32'sh5555_5555, 4'd10);
    offer(REQ_ENQUEUE, 32'shaaaa_aaaa, 4'd5);
    offer(REQ_PEEK, 32'sd1, 4'd9);
    offer(REQ_SPARE, 32'sd2, 4'd6);
    repeat (7) offer(REQ_DEQUEUE, -32'sd1, 4'd15);
    offer(REQ_PEEK, 32'sd0, 4'd0);
    wait_drained();

    // long receiver hold-off while the sender keeps offering
    hold_seq++;
    run_burst(BURST_MIXED, 40);
    wait_drained();

    run_phase(0, 0);
    run_phase(60, 0);
    run_phase(0, 60);
    run_phase(14, 14);

    if (fail_total == 0) begin
      $display("fifo_per_level_priority_queue_unit_tb: done, clean");
    end else begin
      $display("fifo_per_level_priority_queue_unit_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("fifo_per_level_priority_queue_unit_tb: done, errors");
    $finish;
  end

endmodule : fifo_per_level_priority_queue_unit_tb
